FILE: hw/rtl/sensor_frame_receiver_unit_macros.svh
// assertion macros used by the sensor frame receiver rtl
`ifndef SENSOR_FRAME_RECEIVER_UNIT_MACROS_SVH
`define SENSOR_FRAME_RECEIVER_UNIT_MACROS_SVH

`ifndef SYNTH
// antecedent holds in the same cycle as the consequent
`define SFR_ASSERT_IMPLIES(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("sfr assertion failed");
// consequent holds in the cycle after the antecedent
`define SFR_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("sfr assertion failed");
`else
`define SFR_ASSERT_IMPLIES(label, clk, rst, ante, cons)
`define SFR_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif

`endif

FILE: hw/rtl/sfr_pkg.sv
// types and constants of the sensor frame receiver
`timescale 1ns / 1ps

package sfr_pkg;

  localparam int unsigned BYTE_W = 8;

  // register map
  localparam int unsigned APB_ADDR_W = 3;
  localparam logic [APB_ADDR_W-1:0] REG_HEADER_BYTE = 3'd0;
  localparam logic [BYTE_W-1:0] HEADER_BYTE_RESET = 8'h5A;

  // frame byte positions of the value fields
  localparam int unsigned TEMP_BYTE     = 4;
  localparam int unsigned PRESS_BYTE    = 6;
  localparam int unsigned HUM_BYTE      = 10;
  localparam int unsigned ALT_BYTE      = 12;
  localparam int unsigned FIRST_VAL_BYTE = 4;
  localparam int unsigned LAST_VAL_BYTE  = 13;

  // result payload width, padded to whole bytes
  localparam int unsigned RESULT_BITS = 81;
  localparam int unsigned RESULT_W = 88;

  // control from the frame controller to the cell chain and result register
  typedef struct packed {
    logic shift_en;
    logic frame_done;
    logic checksum_ok;
  } sfr_ctl_t;

endpackage

FILE: hw/rtl/sfr_cell.sv
// one byte cell of the frame shift chain
`timescale 1ns / 1ps

module sfr_cell (
  input  logic                          clk,
  input  logic                          shift_en,
  input  logic [sfr_pkg::BYTE_W-1:0]    d,
  output logic [sfr_pkg::BYTE_W-1:0]    q
);

  // take the neighbor's byte on every shift
  always_ff @(posedge clk) begin
    if (shift_en) begin
      q <= d;
    end
  end

endmodule

FILE: hw/rtl/sfr_ctrl.sv
// header hunt, byte position and running checksum of the frame receiver
`timescale 1ns / 1ps
`include "sensor_frame_receiver_unit_macros.svh"

module sfr_ctrl #(
  parameter int unsigned FRAME_BYTES = 15
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        accept,
  input  logic [sfr_pkg::BYTE_W-1:0]  rx_byte,
  input  logic [sfr_pkg::BYTE_W-1:0]  header_byte,
  output sfr_pkg::sfr_ctl_t           ctl
);

  localparam int unsigned PosW = $clog2(FRAME_BYTES);
  localparam logic [PosW-1:0] LastPos = PosW'(FRAME_BYTES - 1);

  logic [PosW-1:0]               pos;
  logic [PosW-1:0]               pos_next;
  logic [sfr_pkg::BYTE_W-1:0]    sum;
  logic [sfr_pkg::BYTE_W-1:0]    sum_next;
  logic                          hunting;
  logic                          take;
  logic                          last;

  // decide whether the item joins a frame
  always_comb begin
    hunting = (pos == '0);
    take    = accept && (!hunting || (rx_byte == header_byte));
    last    = take && (pos == LastPos);
  end

  // next position and running sum
  always_comb begin
    pos_next = pos;
    sum_next = sum;
    if (last) begin
      pos_next = '0;
      sum_next = '0;
    end else if (take) begin
      pos_next = pos + 1'b1;
      sum_next = hunting ? rx_byte : sum + rx_byte;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pos <= '0;
      sum <= '0;
    end else begin
      pos <= pos_next;
      sum <= sum_next;
    end
  end

  // control out
  always_comb begin
    ctl.shift_en    = take;
    ctl.frame_done  = last;
    ctl.checksum_ok = (sum == rx_byte);
  end

  // rearm after the checksum byte
  `SFR_ASSERT_NEXT(a_rearm_after_frame, clk, rst, ctl.frame_done, pos == '0)
  // a dropped byte while hunting leaves the hunt going
  `SFR_ASSERT_NEXT(a_drop_keeps_hunting, clk, rst,
    accept && hunting && (rx_byte != header_byte), pos == '0)
  // a frame only closes at the last position
  `SFR_ASSERT_IMPLIES(a_done_at_last_pos, clk, rst, ctl.frame_done,
    take && (pos == LastPos))

endmodule

FILE: hw/rtl/sensor_frame_receiver_unit.sv
// top level of the sensor frame receiver: cell chain, control, result register, apb
//
// channel   | dir | payload
// ----------+-----+-------------------------------------------------------
// s_axis    | in  | rx_byte, one received serial byte per item
// m_axis    | out | temperature, pressure, humidity, altitude, checksum_ok
// apb       | in  | header_byte register at byte address 0
//
// one item per clock while the input is not stalled; a frame result leaves in the cycle after its last byte
// the byte chain shifts one cell per accepted frame byte, bytes out of a
// frame are dropped without shifting
// synchronous active-high reset clears position, sum, result valid and
// sets header_byte to 0x5a
// input stalls only while a result is held and the output is not ready
`timescale 1ns / 1ps

module sensor_frame_receiver_unit #(
  parameter int unsigned FRAME_BYTES = 15
) (
  input  logic                                 clk,
  input  logic                                 rst,
  // input stream
  input  logic                                 s_tvalid,
  output logic                                 s_tready,
  input  logic [7:0]                           s_tdata,   // [7:0] rx_byte
  // result stream
  output logic                                 m_tvalid,
  input  logic                                 m_tready,
  // [15:0] temperature_raw, [47:16] pressure_raw, [63:48] humidity_raw,
  // [79:64] altitude_raw, [80] checksum_ok, [87:81] zero
  output logic [sfr_pkg::RESULT_W-1:0]         m_tdata,
  // configuration
  input  logic                                 psel,
  input  logic                                 penable,
  input  logic                                 pwrite,
  input  logic [sfr_pkg::APB_ADDR_W-1:0]       paddr,
  input  logic [31:0]                          pwdata,
  output logic [31:0]                          prdata,
  output logic                                 pready
);

  localparam int unsigned Cells = FRAME_BYTES - 1;

  logic [sfr_pkg::BYTE_W-1:0] header_byte;
  logic                       accept;
  sfr_pkg::sfr_ctl_t          ctl;
  logic [sfr_pkg::BYTE_W-1:0] cell_q [Cells];
  logic [sfr_pkg::BYTE_W-1:0] fbyte [sfr_pkg::FIRST_VAL_BYTE:sfr_pkg::LAST_VAL_BYTE];
  logic [sfr_pkg::RESULT_BITS-1:0] result;

  // apb register
  assign pready = 1'b1;
  assign prdata = {24'd0, header_byte};

  always_ff @(posedge clk) begin
    if (rst) begin
      header_byte <= sfr_pkg::HEADER_BYTE_RESET;
    end else if (psel && penable && pwrite && pready
                 && (paddr == sfr_pkg::REG_HEADER_BYTE)) begin
      header_byte <= pwdata[sfr_pkg::BYTE_W-1:0];
    end
  end

  // input handshake: the result register parts the two sides
  assign s_tready = !m_tvalid || m_tready;
  assign accept   = s_tvalid && s_tready;

  sfr_ctrl #(
    .FRAME_BYTES (FRAME_BYTES)
  ) u_ctrl (
    .clk         (clk),
    .rst         (rst),
    .accept      (accept),
    .rx_byte     (s_tdata),
    .header_byte (header_byte),
    .ctl         (ctl)
  );

  // byte chain: cell 0 takes the new byte, older bytes move up
  for (genvar i = 0; i < Cells; i++) begin : g_cell
    if (i == 0) begin : g_head
      sfr_cell u_cell (
        .clk      (clk),
        .shift_en (ctl.shift_en),
        .d        (s_tdata),
        .q        (cell_q[i])
      );
    end else begin : g_body
      sfr_cell u_cell (
        .clk      (clk),
        .shift_en (ctl.shift_en),
        .d        (cell_q[i-1]),
        .q        (cell_q[i])
      );
    end
  end

  // frame byte k sits in cell FRAME_BYTES-2-k when the checksum byte arrives
  for (genvar k = sfr_pkg::FIRST_VAL_BYTE; k <= sfr_pkg::LAST_VAL_BYTE; k++) begin : g_byte
    if (k <= FRAME_BYTES - 2) begin : g_cell_byte
      assign fbyte[k] = cell_q[FRAME_BYTES-2-k];
    end else if (k == FRAME_BYTES - 1) begin : g_sum_byte
      assign fbyte[k] = s_tdata;
    end else begin : g_absent
      assign fbyte[k] = '0;
    end
  end

  // assemble the big-endian value fields
  assign result = {
    ctl.checksum_ok,
    fbyte[sfr_pkg::ALT_BYTE], fbyte[sfr_pkg::ALT_BYTE+1],
    fbyte[sfr_pkg::HUM_BYTE], fbyte[sfr_pkg::HUM_BYTE+1],
    fbyte[sfr_pkg::PRESS_BYTE], fbyte[sfr_pkg::PRESS_BYTE+1],
    fbyte[sfr_pkg::PRESS_BYTE+2], fbyte[sfr_pkg::PRESS_BYTE+3],
    fbyte[sfr_pkg::TEMP_BYTE], fbyte[sfr_pkg::TEMP_BYTE+1]
  };

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (ctl.frame_done) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.frame_done) begin
      m_tdata <= {(sfr_pkg::RESULT_W - sfr_pkg::RESULT_BITS)'(0), result};
    end
  end

endmodule

FILE: bench/testbench.sv
// self-checking bench for sensor_frame_receiver_unit: frame stream, apb header writes, scoreboard
`timescale 1ns / 1ps

module testbench;
  import sfr_pkg::*;

  localparam int unsigned FRAME_BYTES = 15;
  localparam int unsigned IDLE_PCT = 11;
  localparam int unsigned RANDOM_ITEMS = 500;
  localparam int unsigned PHASES = 4;
  localparam int unsigned SETTLE_CYCLES = 4;
  localparam int unsigned CYCLE_LIMIT = 100000;
  // register index 4 does not exist, writes there must be dropped
  localparam logic [APB_ADDR_W-1:0] UNUSED_REG_ADDR = REG_HEADER_BYTE + 3'd4;

  // one decoded frame as it sits in m_tdata, lowest field last
  typedef struct packed {
    logic [RESULT_W-RESULT_BITS-1:0] pad;
    logic                            checksum_ok;
    logic [15:0]                     altitude_raw;
    logic [15:0]                     humidity_raw;
    logic [31:0]                     pressure_raw;
    logic [15:0]                     temperature_raw;
  } sensor_reading_t;

  // frame decoder model and queue of readings still to come out
  class frame_scoreboard;
    logic [BYTE_W-1:0] header;
    int unsigned       position;
    logic [BYTE_W-1:0] running_sum;
    logic [BYTE_W-1:0] frame_bytes [FRAME_BYTES];
    sensor_reading_t   readings_due [$];
    int unsigned       errors;

    function new();
      header = HEADER_BYTE_RESET;
      position = 0;
      running_sum = '0;
      errors = 0;
      foreach (frame_bytes[i]) frame_bytes[i] = '0;
    endfunction

    function void set_header(logic [BYTE_W-1:0] value);
      header = value;
    endfunction

    // bytes past the end of a short frame read as zero
    function logic [BYTE_W-1:0] frame_byte(int unsigned idx);
      if (idx >= FRAME_BYTES) return '0;
      return frame_bytes[idx];
    endfunction

    function logic [15:0] big_endian16(int unsigned idx);
      return {frame_byte(idx), frame_byte(idx + 1)};
    endfunction

    // one accepted rx byte
    function void note_byte(logic [BYTE_W-1:0] rx);
      sensor_reading_t reading;
      if (position >= FRAME_BYTES) position = 0;
      // hunting: drop everything but the header
      if (position == 0) begin
        if (rx != header) return;
        running_sum = '0;
      end
      frame_bytes[position] = rx;
      if (position + 1 < FRAME_BYTES) begin
        running_sum = running_sum + rx;
        position++;
        return;
      end
      // last byte is the checksum
      reading.pad = '0;
      reading.checksum_ok = (running_sum == rx);
      reading.temperature_raw = big_endian16(TEMP_BYTE);
      reading.pressure_raw = {big_endian16(PRESS_BYTE), big_endian16(PRESS_BYTE + 2)};
      reading.humidity_raw = big_endian16(HUM_BYTE);
      reading.altitude_raw = big_endian16(ALT_BYTE);
      readings_due.push_back(reading);
      position = 0;
      running_sum = '0;
    endfunction

    function void compare_field(string name, logic [31:0] want, logic [31:0] got);
      if (want !== got) begin
        errors++;
        $display("%0t %s mismatch: expected %h, actual %h", $time, name, want, got);
      end
    endfunction

    // one accepted result item
    function void check_result(logic [RESULT_W-1:0] word);
      sensor_reading_t got;
      sensor_reading_t want;
      got = word;
      if (readings_due.size() == 0) begin
        errors++;
        $display("%0t unexpected result: expected none, actual %h", $time, word);
        return;
      end
      want = readings_due.pop_front();
      compare_field("temperature_raw", want.temperature_raw, got.temperature_raw);
      compare_field("pressure_raw", want.pressure_raw, got.pressure_raw);
      compare_field("humidity_raw", want.humidity_raw, got.humidity_raw);
      compare_field("altitude_raw", want.altitude_raw, got.altitude_raw);
      compare_field("checksum_ok", want.checksum_ok, got.checksum_ok);
      compare_field("padding", want.pad, got.pad);
    endfunction
  endclass

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  s_tvalid = 1'b0;
  logic                  s_tready;
  logic [7:0]            s_tdata = '0;    // [7:0] rx_byte
  logic                  m_tvalid;
  logic                  m_tready = 1'b0;
  // [15:0] temperature_raw, [47:16] pressure_raw, [63:48] humidity_raw,
  // [79:64] altitude_raw, [80] checksum_ok, [87:81] zero
  logic [RESULT_W-1:0]   m_tdata;
  logic                  psel = 1'b0;
  logic                  penable = 1'b0;
  logic                  pwrite = 1'b0;
  logic [APB_ADDR_W-1:0] paddr = '0;
  logic [31:0]           pwdata = '0;
  logic [31:0]           prdata;
  logic                  pready;

  bit                    steady = 1'b0;
  int unsigned           cycle_count = 0;
  int unsigned           items_sent;
  frame_scoreboard       board;

  sensor_frame_receiver_unit #(
    .FRAME_BYTES(FRAME_BYTES)
  ) u_top (
    .clk(clk),
    .rst(rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata(s_tdata),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata(m_tdata),
    .psel(psel),
    .penable(penable),
    .pwrite(pwrite),
    .paddr(paddr),
    .pwdata(pwdata),
    .prdata(prdata),
    .pready(pready)
  );

  always #10 clk = ~clk;

  // run limit
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("FAIL sensor_frame_receiver_unit");
      $finish;
    end
  end

  // result side: random backpressure and checking
  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      if (m_tvalid && m_tready) board.check_result(m_tdata);
      m_tready <= steady || ($urandom_range(0, 99) >= IDLE_PCT);
    end
  end

  // random byte, biased toward the extremes and the current header
  function automatic logic [7:0] pick_byte();
    case ($urandom_range(0, 9))
      0: return 8'h00;
      1: return 8'hFF;
      2: return board.header;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  // present one item and hold it until accepted
  task automatic send_byte(input logic [7:0] rx);
    while (!steady && $urandom_range(0, 99) < IDLE_PCT) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= rx;
    do @(posedge clk); while (!s_tready);
    board.note_byte(rx);
    items_sent++;
  endtask

  // stop the input and let every pending result drain
  task automatic drain();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (board.readings_due.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic apb_write(input logic [APB_ADDR_W-1:0] addr, input logic [31:0] data);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= addr;
    pwdata <= data;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    if (addr == REG_HEADER_BYTE) board.set_header(data[BYTE_W-1:0]);
  endtask

  // a well-formed frame with random content, good or bad checksum
  task automatic send_frame(input bit good);
    logic [7:0] frame [FRAME_BYTES];
    logic [7:0] total;
    frame[0] = board.header;
    total = frame[0];
    for (int i = 1; i < FRAME_BYTES - 1; i++) begin
      frame[i] = pick_byte();
      total = total + frame[i];
    end
    frame[FRAME_BYTES-1] = good ? total : pick_byte();
    for (int i = 0; i < FRAME_BYTES; i++) send_byte(frame[i]);
  endtask

  initial begin
    logic [7:0] directed [FRAME_BYTES];
    logic [7:0] total;
    logic [7:0] phase_header;
    int unsigned phase_goal;

    board = new();
    items_sent = 0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // junk while hunting, then a good frame of all-ones fields that carries
    // the header value as data; header switches to 0xff halfway through
    send_byte(8'h00);
    send_byte(8'hFF);
    directed = '{8'h5A, 8'h01, 8'h5A, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF,
                 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'h00};
    total = '0;
    for (int i = 0; i < FRAME_BYTES - 1; i++) total = total + directed[i];
    directed[FRAME_BYTES-1] = total;
    for (int i = 0; i < 7; i++) send_byte(directed[i]);
    drain();
    apb_write(REG_HEADER_BYTE, 32'h0000_00FF);
    for (int i = 7; i < FRAME_BYTES; i++) send_byte(directed[i]);

    // old header is now junk; write to a missing register is dropped
    send_byte(8'h5A);
    drain();
    apb_write(UNUSED_REG_ADDR, 32'h0000_0033);

    // all-zero fields with a failed checksum
    send_byte(8'hFF);
    for (int i = 1; i < FRAME_BYTES - 1; i++) send_byte(8'h00);
    send_byte(8'h01);

    // random phases under different header values
    for (int phase = 0; phase < PHASES; phase++) begin
      drain();
      case (phase)
        0: phase_header = 8'h00;
        1: phase_header = HEADER_BYTE_RESET;
        2: phase_header = 8'hFF;
        default: phase_header = 8'($urandom_range(0, 255));
      endcase
      apb_write(REG_HEADER_BYTE, {24'h0, phase_header});
      // one phase runs with no idling on either side
      steady <= (phase == 2);
      phase_goal = items_sent + RANDOM_ITEMS / PHASES;
      while (items_sent < phase_goal) begin
        // noise between frames, now and then a stray header
        repeat ($urandom_range(0, 3)) begin
          if ($urandom_range(0, 19) == 0) send_byte(board.header);
          else send_byte(pick_byte());
        end
        // finish any frame the noise opened
        while (board.position != 0) send_byte(pick_byte());
        send_frame($urandom_range(0, 9) < 7);
      end
    end

    drain();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (board.errors == 0 && board.readings_due.size() == 0) begin
      $display("PASS sensor_frame_receiver_unit");
    end else begin
      $display("FAIL sensor_frame_receiver_unit");
    end
    $finish;
  end

endmodule
